// ===== design/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for the barometric compensation block
// Register indexes, field widths and the shared multiplier request and response types.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int unsigned PressurePerTemp = 4;
   localparam int unsigned PhaseW = 3;

   localparam int unsigned AdcW   = 24;
   localparam int unsigned CoefW  = 16;
   localparam int unsigned TofsW  = 12;
   localparam int unsigned TempW  = 15;
   localparam int unsigned PresW  = 17;
   localparam int unsigned AccW   = 66;

   localparam logic [AdcW-1:0] AdcAllOnes = '1;

   localparam logic [2:0] RegSens     = 3'd0;
   localparam logic [2:0] RegOff      = 3'd1;
   localparam logic [2:0] RegTcs      = 3'd2;
   localparam logic [2:0] RegTco      = 3'd3;
   localparam logic [2:0] RegTref     = 3'd4;
   localparam logic [2:0] RegTempsens = 3'd5;
   localparam logic [2:0] RegTofs     = 3'd6;

   localparam logic signed [AccW-1:0] TempMin = -66'sd8000;
   localparam logic signed [AccW-1:0] TempMax = 66'sd12000;
   localparam logic signed [AccW-1:0] PresMax = 66'sd131071;

   // Multiply request to the shared serial multiplier.
   typedef struct packed {
      logic                   start;
      logic signed [AccW-1:0] a;
      logic signed [AccW-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                   done;
      logic signed [AccW-1:0] p;
   } mul_rsp_type;

endpackage

// ===== design/baro_sample_sequencer_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_sample_sequencer_compensation: sample sequencer with 2nd-order comp
// One temperature then four pressure results; each pressure beat yields
// compensated temperature and pressure in 0.01 units.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  req      in   valid / stall    adc_value
//  rsp      out  valid / stall    next_conversion, sample_rejected,
//                                 values_valid, temperature_centi, pressure_centi
//  csr      in   valid / ready    index, data
//
// Rejected and temperature beats pass through S_OUT before they show up on rsp.
// A pressure beat runs a sequencer over one shared serial multiplier: four
// products, two more below 20.00 deg and a third below -15.00 deg. Each
// product runs until the remaining bits of its multiplier operand are zero.
// Reset is synchronous and clears control and the calibration registers.
// req_stall is high while an item is at work or a result waits;
// rsp_stall holds the result register.
// ----------------------------------------------------------------------------
module baro_sample_sequencer_compensation (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [23:0]  req_adc_value,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_next_conversion,
   output logic         rsp_sample_rejected,
   output logic         rsp_values_valid,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [16:0]  rsp_pressure_centi,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);
   localparam int unsigned W = bsc_pkg::AccW;

   typedef enum logic [3:0] {
      S_IDLE, S_TEMP, S_OFF, S_SENS, S_DT2, S_A, S_B, S_FIX, S_P, S_DONE, S_OUT
   } state_type;

   state_type state_ff;

   // calibration registers
   logic [15:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   logic signed [11:0] tofs_ff;

   logic [2:0]  phase_ff;
   logic [23:0] d2_ff, d1_ff;
   logic signed [W-1:0] dt_ff, temp_ff, off_ff, sens_ff, t2_ff, off2_ff, sens2_ff;

   bsc_pkg::mul_req_type mreq;
   bsc_pkg::mul_rsp_type mrsp;
   logic                 wait_ff;

   // result register
   logic rv_ff, nc_ff, rj_ff, vv_ff;
   logic signed [14:0] tc_ff;
   logic [16:0] pc_ff;

   logic signed [W-1:0] mp, tsum, pval;

   bsc_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   assign mp = mrsp.p;
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign tsum = temp_ff + W'(tofs_ff);
   assign pval = off_ff >>> 15;

   // operand selection for the step issued in each state
   always_comb begin
      mreq.start = 1'b0;
      mreq.a = '0;
      mreq.b = '0;
      if (!wait_ff) begin
         case (state_ff)
            S_TEMP: begin mreq.start = 1'b1; mreq.a = dt_ff; mreq.b = W'(c6_ff); end
            S_OFF:  begin mreq.start = 1'b1; mreq.a = dt_ff; mreq.b = W'(c4_ff); end
            S_SENS: begin mreq.start = 1'b1; mreq.a = dt_ff; mreq.b = W'(c3_ff); end
            S_DT2:  begin mreq.start = 1'b1; mreq.a = dt_ff;
                          mreq.b = dt_ff[W-1] ? -dt_ff : dt_ff;
                          mreq.a = dt_ff[W-1] ? -dt_ff : dt_ff; end
            S_A:    begin mreq.start = 1'b1; mreq.a = W'(2000) - temp_ff;
                          mreq.b = (temp_ff[W-1] || temp_ff < W'(2000)) ?
                                   W'(2000) - temp_ff : temp_ff - W'(2000); end
            S_B:    begin mreq.start = 1'b1; mreq.a = temp_ff + W'(1500);
                          mreq.b = -(temp_ff + W'(1500)); end
            S_P:    begin mreq.start = 1'b1; mreq.a = sens_ff; mreq.b = W'(d1_ff); end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= '0;
         rv_ff    <= 1'b0;
         wait_ff  <= 1'b0;
         c1_ff <= '0; c2_ff <= '0; c3_ff <= '0; c4_ff <= '0;
         c5_ff <= '0; c6_ff <= '0; tofs_ff <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               bsc_pkg::RegSens:     c1_ff <= csr_data;
               bsc_pkg::RegOff:      c2_ff <= csr_data;
               bsc_pkg::RegTcs:      c3_ff <= csr_data;
               bsc_pkg::RegTco:      c4_ff <= csr_data;
               bsc_pkg::RegTref:     c5_ff <= csr_data;
               bsc_pkg::RegTempsens: c6_ff <= csr_data;
               bsc_pkg::RegTofs:     tofs_ff <= csr_data[11:0];
               default: ;
            endcase
         end
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         if (mreq.start) wait_ff <= 1'b1;
         if (mrsp.done) wait_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !rv_ff) begin
                  vv_ff <= 1'b0;
                  tc_ff <= '0;   pc_ff <= '0;
                  if (req_adc_value == '0 || req_adc_value == bsc_pkg::AdcAllOnes) begin
                     rj_ff <= 1'b1;
                     nc_ff <= (phase_ff != '0);
                     state_ff <= S_OUT;
                  end else if (phase_ff == '0) begin
                     rj_ff <= 1'b0;
                     nc_ff <= 1'b1;
                     d2_ff <= req_adc_value;
                     phase_ff <= 3'd1;
                     state_ff <= S_OUT;
                  end else begin
                     rj_ff <= 1'b0;
                     d1_ff <= req_adc_value;
                     dt_ff <= W'(d2_ff) - (W'(c5_ff) <<< 8);
                     state_ff <= S_TEMP;
                  end
               end
            end
            S_TEMP: if (mrsp.done) begin
               temp_ff <= W'(2000) + (mp >>> 23);
               state_ff <= S_OFF;
            end
            S_OFF: if (mrsp.done) begin
               off_ff <= (W'($signed({1'b0, c2_ff})) <<< 16) + (mp >>> 7);
               state_ff <= S_SENS;
            end
            S_SENS: if (mrsp.done) begin
               sens_ff <= (W'($signed({1'b0, c1_ff})) <<< 15) + (mp >>> 8);
               state_ff <= (temp_ff < W'(2000)) ? S_DT2 : S_P;
            end
            S_DT2: if (mrsp.done) begin
               t2_ff <= mp >>> 31;
               state_ff <= S_A;
            end
            S_A: if (mrsp.done) begin
               off2_ff  <= ((mp <<< 2) + mp) >>> 1;
               sens2_ff <= ((mp <<< 2) + mp) >>> 2;
               state_ff <= (temp_ff < -W'(1500)) ? S_B : S_FIX;
            end
            S_B: if (mrsp.done) begin
               // mp = a * b = -(temp + 1500)^2
               off2_ff  <= off2_ff - ((mp <<< 3) - mp);
               sens2_ff <= sens2_ff + ((-((mp <<< 3) + (mp <<< 1) + mp)) >>> 1);
               state_ff <= S_FIX;
            end
            S_FIX: begin
               temp_ff <= temp_ff - t2_ff;
               off_ff  <= off_ff - off2_ff;
               sens_ff <= sens_ff - sens2_ff;
               state_ff <= S_P;
            end
            S_P: if (mrsp.done) begin
               off_ff <= (mp >>> 21) - off_ff;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               vv_ff <= 1'b1;
               if (tsum < bsc_pkg::TempMin) tc_ff <= -15'sd8000;
               else if (tsum > bsc_pkg::TempMax) tc_ff <= 15'sd12000;
               else tc_ff <= tsum[14:0];
               if (pval[W-1]) pc_ff <= '0;
               else if (pval > bsc_pkg::PresMax) pc_ff <= '1;
               else pc_ff <= pval[16:0];
               if (phase_ff >= 3'(bsc_pkg::PressurePerTemp)) begin
                  phase_ff <= '0;
                  nc_ff <= 1'b0;
               end else begin
                  phase_ff <= phase_ff + 3'd1;
                  nc_ff <= 1'b1;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rv_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid             = rv_ff;
   assign rsp_next_conversion   = nc_ff;
   assign rsp_sample_rejected   = rj_ff;
   assign rsp_values_valid      = vv_ff;
   assign rsp_temperature_centi = tc_ff;
   assign rsp_pressure_centi    = pc_ff;

endmodule

// ===== design/bsc_mul.sv =====
// ----------------------------------------------------------------------------
// bsc_mul: shared shift-add multiplier
// Signed multiply, two bits of the multiplier per cycle. Stops once the
// remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module bsc_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  bsc_pkg::mul_req_type req,
   output bsc_pkg::mul_rsp_type rsp
);
   localparam int unsigned W = bsc_pkg::AccW;

   logic signed [W-1:0] acc_ff, acc_in;
   logic signed [W-1:0] mcand_ff, mcand_in;
   logic        [W-1:0] mplier_ff, mplier_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic signed [W-1:0] part;

   // Modulo 2^W arithmetic gives the exact signed product when it fits.
   always_comb begin
      part = '0;
      if (mplier_ff[0]) part = mcand_ff;
      if (mplier_ff[1]) part = part + (mcand_ff <<< 1);
   end

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (req.start) begin
         acc_in    = '0;
         mcand_in  = req.a;
         mplier_in = req.b;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = acc_ff + part;
         mcand_in  = mcand_ff <<< 2;
         mplier_in = mplier_ff >> 2;
         if ((mplier_ff >> 2) == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign rsp.done = done_ff;
   assign rsp.p    = acc_ff;

endmodule
